// ===== src/gsrd_pkg.sv =====
// Shared constants, types and the CRC-8 function of the gas sensor response decoder.
package gsrd_pkg;

   // Response byte layout and CRC-8 (polynomial x^8 + x^5 + x^4 + 1).
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Word store sizing: a measurement frame carries up to three words.
   localparam int MAX_WORDS       = 3;
   localparam int MEAS_WORDS      = 3;
   localparam int FRAME_WORDS_MAX = (MEAS_WORDS < MAX_WORDS) ? MEAS_WORDS : MAX_WORDS;
   localparam int WORD_CNT_W      = $clog2(FRAME_WORDS_MAX + 1);

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int TEMP_W   = 15;
   localparam int HUMID_W  = 14;

   // Frame kinds, latched on the first byte of a response.
   localparam logic [KIND_W-1:0] KIND_MEAS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECAL  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERROR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RECAL_FAIL = 2'd2;

   localparam logic [WORD_W-1:0] RECAL_FAIL_WORD = 16'hFFFF;
   localparam logic [WORD_W-1:0] READY_MASK      = 16'h07FF;

   // A completed frame as handed from the parser to the converter.
   typedef struct packed {
      logic [KIND_W-1:0]                 kind;
      logic                              crc_failed;
      logic [MEAS_WORDS-1:0][WORD_W-1:0] words;
   } frame_type;

   // One byte through the CRC-8 register, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/gsrd_channels.sv =====
// Request and response channel interfaces of the gas sensor response decoder.
interface gsrd_req_if
   import gsrd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              first;
   logic [KIND_W-1:0] func;

   modport source (output valid, output rx_byte, output first, output func, input ready);
   modport sink   (input valid, input rx_byte, input first, input func, output ready);
endinterface

interface gsrd_rsp_if
   import gsrd_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic [WORD_W-1:0]          co2_ppm;
   logic signed [TEMP_W-1:0]   temperature_centi;
   logic [HUMID_W-1:0]         humidity_centi;
   logic                       data_avail;
   logic [WORD_W-1:0]          recal_correction;

   modport source (output valid, output status, output co2_ppm, output temperature_centi,
                   output humidity_centi, output data_avail, output recal_correction,
                   input ready);
   modport sink   (input valid, input status, input co2_ppm, input temperature_centi,
                   input humidity_centi, input data_avail, input recal_correction,
                   output ready);
endinterface

// ===== src/gsrd_parser.sv =====
// Byte parser: input register, frame tracking, CRC check and word store.
module gsrd_parser
   import gsrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   gsrd_req_if.sink        req_if,
   output logic            frm_valid,
   input  logic            frm_ready,
   output frame_type       frm
);

   typedef enum logic [2:0] {
      PH_MSB = 3'b001,
      PH_LSB = 3'b010,
      PH_CRC = 3'b100
   } phase_type;

   logic                          in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]             in_byte_ff;
   logic                          in_first_ff;
   logic [KIND_W-1:0]             in_func_ff;

   logic [KIND_W-1:0]             kind_ff, kind_in;
   phase_type                     phase_ff, phase_in;
   logic [WORD_CNT_W-1:0]         word_ff, word_in;
   logic                          crc_failed_ff, crc_failed_in;
   logic [BYTE_W-1:0]             high_ff, high_in;
   logic [BYTE_W-1:0]             low_ff, low_in;
   logic [WORD_W-1:0]             store_ff [FRAME_WORDS_MAX];
   logic [WORD_W-1:0]             store_in [FRAME_WORDS_MAX];

   logic                          frm_valid_ff, frm_valid_in;
   frame_type                     frm_ff;

   logic [KIND_W-1:0]             kind_eff;
   phase_type                     phase_eff;
   logic [WORD_CNT_W-1:0]         word_eff;
   logic                          crc_fail_eff;
   logic [WORD_CNT_W-1:0]         words;
   logic                          active;
   logic                          frame_done;
   logic                          s1_go;
   logic [BYTE_W-1:0]             crc_calc;
   logic [MEAS_WORDS-1:0][WORD_W-1:0] view;

   // A marked first byte restarts the frame before the byte itself is parsed.
   always_comb begin
      kind_eff     = in_first_ff ? in_func_ff : kind_ff;
      phase_eff    = in_first_ff ? PH_MSB : phase_ff;
      word_eff     = in_first_ff ? '0 : word_ff;
      crc_fail_eff = in_first_ff ? 1'b0 : crc_failed_ff;
      words        = (kind_eff == KIND_MEAS) ? WORD_CNT_W'(FRAME_WORDS_MAX)
                                             : WORD_CNT_W'(1);
      active       = (word_eff < words);
      frame_done   = in_valid_ff && active && (phase_eff == PH_CRC)
                     && (word_eff == words - WORD_CNT_W'(1));
      crc_calc     = crc8_byte(crc8_byte(CRC_INIT, high_ff), low_ff);
      // Bytes that do not close a frame never wait on the frame register.
      s1_go        = in_valid_ff && (!frame_done || !frm_valid_ff || frm_ready);
   end

   assign req_if.ready = !in_valid_ff || s1_go;

   always_comb begin
      kind_in       = kind_ff;
      phase_in      = phase_ff;
      word_in       = word_ff;
      crc_failed_in = crc_failed_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      store_in      = store_ff;
      if (s1_go) begin
         kind_in       = kind_eff;
         phase_in      = phase_eff;
         word_in       = word_eff;
         crc_failed_in = crc_fail_eff;
         if (active) begin
            unique case (phase_eff)
               PH_MSB: begin
                  high_in  = in_byte_ff;
                  phase_in = PH_LSB;
               end
               PH_LSB: begin
                  low_in   = in_byte_ff;
                  phase_in = PH_CRC;
               end
               PH_CRC: begin
                  if (crc_calc != in_byte_ff) begin
                     crc_failed_in = 1'b1;
                  end
                  for (int i = 0; i < FRAME_WORDS_MAX; i++) begin
                     if (word_eff == WORD_CNT_W'(i)) begin
                        store_in[i] = {high_ff, low_ff};
                     end
                  end
                  phase_in = PH_MSB;
                  word_in  = word_eff + WORD_CNT_W'(1);
               end
               default: begin
                  phase_in = PH_MSB;
               end
            endcase
         end
      end
   end

   // Words beyond the store read as zero.
   for (genvar g = 0; g < MEAS_WORDS; g++) begin : g_view
      if (g < FRAME_WORDS_MAX) begin : g_stored
         assign view[g] = store_in[g];
      end else begin : g_absent
         assign view[g] = '0;
      end
   end

   always_comb begin
      if (s1_go && frame_done) begin
         frm_valid_in = 1'b1;
      end else if (frm_ready) begin
         frm_valid_in = 1'b0;
      end else begin
         frm_valid_in = frm_valid_ff;
      end
      in_valid_in = req_if.ready ? req_if.valid : in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         kind_ff       <= KIND_MEAS;
         phase_ff      <= PH_MSB;
         word_ff       <= '0;
         crc_failed_ff <= 1'b0;
         frm_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         kind_ff       <= kind_in;
         phase_ff      <= phase_in;
         word_ff       <= word_in;
         crc_failed_ff <= crc_failed_in;
         frm_valid_ff  <= frm_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff  <= req_if.rx_byte;
         in_first_ff <= req_if.first;
         in_func_ff  <= req_if.func;
      end
      high_ff  <= high_in;
      low_ff   <= low_in;
      store_ff <= store_in;
      if (s1_go && frame_done) begin
         frm_ff.kind       <= kind_eff;
         frm_ff.crc_failed <= crc_failed_in;
         frm_ff.words      <= view;
      end
   end

   assign frm_valid = frm_valid_ff;
   assign frm       = frm_ff;

endmodule

// ===== src/gsrd_converter.sv =====
// Converter: scales a completed frame into engineering units and holds the result register.
module gsrd_converter
   import gsrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            frm_valid,
   output logic            frm_ready,
   input  frame_type       frm,
   gsrd_rsp_if.source      rsp_if
);

   localparam logic [14:0]       TEMP_SPAN   = 15'd17500;
   localparam logic [14:0]       HUMID_SPAN  = 15'd10000;
   localparam logic [30:0]       ROUND_HALF  = 31'd32767;
   localparam logic [16:0]       SCALE_DIV   = 17'd65535;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;

   // floor((k*w + 32767) / 65535). The quotient estimate x>>16 is at most one short,
   // since the remainder it leaves stays below twice the divisor.
   function automatic logic [14:0] scale_word(input logic [WORD_W-1:0] w,
                                              input logic [14:0] k);
      logic [30:0] x;
      logic [14:0] q0;
      logic [16:0] r;
      x  = (31'(k) * 31'(w)) + ROUND_HALF;
      q0 = x[30:16];
      r  = {1'b0, x[15:0]} + 17'(q0);
      return (r >= SCALE_DIV) ? (q0 + 15'd1) : q0;
   endfunction

   logic                     out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [WORD_W-1:0]        co2_ff, co2_in;
   logic [TEMP_W-1:0]        temp_ff, temp_in;
   logic [HUMID_W-1:0]       humid_ff, humid_in;
   logic                     ready_flag_ff, ready_flag_in;
   logic [WORD_W-1:0]        corr_ff, corr_in;
   logic [14:0]              temp_q, humid_q;
   logic                     load;

   assign frm_ready = !out_valid_ff || rsp_if.ready;
   assign load      = frm_valid && frm_ready;

   always_comb begin
      temp_q        = scale_word(frm.words[1], TEMP_SPAN);
      humid_q       = scale_word(frm.words[2], HUMID_SPAN);
      status_in     = STATUS_OK;
      co2_in        = '0;
      temp_in       = '0;
      humid_in      = '0;
      ready_flag_in = 1'b0;
      corr_in       = '0;
      if (frm.crc_failed) begin
         status_in = STATUS_CRC_ERROR;
      end else begin
         case (frm.kind)
            KIND_MEAS: begin
               co2_in   = frm.words[0];
               temp_in  = temp_q - TEMP_OFFSET;
               humid_in = HUMID_W'(humid_q);
            end
            KIND_STATUS: begin
               ready_flag_in = |(frm.words[0] & READY_MASK);
            end
            KIND_RECAL: begin
               corr_in = frm.words[0];
               if (frm.words[0] == RECAL_FAIL_WORD) begin
                  status_in = STATUS_RECAL_FAIL;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff     <= status_in;
         co2_ff        <= co2_in;
         temp_ff       <= temp_in;
         humid_ff      <= humid_in;
         ready_flag_ff <= ready_flag_in;
         corr_ff       <= corr_in;
      end
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.status            = status_ff;
   assign rsp_if.co2_ppm           = co2_ff;
   assign rsp_if.temperature_centi = $signed(temp_ff);
   assign rsp_if.humidity_centi    = humid_ff;
   assign rsp_if.data_avail        = ready_flag_ff;
   assign rsp_if.recal_correction  = corr_ff;

endmodule

// ===== src/gas_sensor_response_decoder.sv =====
// Top level of the gas sensor response decoder.
//
// The decoder takes one response byte per request and, when the last CRC byte of a frame
// has been taken, gives one result: a measurement frame (three MSB, LSB, CRC triples)
// yields CO2 in ppm, temperature in hundredths of a degree and humidity in hundredths of
// a percent; a status frame yields the data available flag; a recalibration frame yields
// the correction word, with a failure status for the all-ones word. Any CRC-8 mismatch in
// a frame gives a CRC error status with all values zero. A byte marked first restarts
// parsing with the frame kind it carries; bytes after a complete frame are dropped until
// the next first byte. The block takes one request every clock cycle while request ready is
// high: bytes pass through an input register, a frame register and the result register, in
// that order. Request ready falls only while a closing byte waits behind a full frame
// register and an untaken result, so at most two results can be held back before the
// input stalls.
module gas_sensor_response_decoder
   import gsrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   gsrd_req_if.sink        req_if,
   gsrd_rsp_if.source      rsp_if
);

   logic      frm_valid;
   logic      frm_ready;
   frame_type frm;

   // Byte parser: frame tracking, CRC check and word store.
   gsrd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm       (frm)
   );

   // Unit scaling and the result register.
   gsrd_converter u_converter (
      .clock     (clock),
      .reset     (reset),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm       (frm),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTHESIS
   // A new result only appears after a completed frame was handed to the converter.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(frm_valid && frm_ready))
      else $error("result appeared without a completed frame");

   // A recalibration failure always reports the all-ones correction word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status == STATUS_RECAL_FAIL))
         |-> (rsp_if.recal_correction == RECAL_FAIL_WORD))
      else $error("recalibration failure with wrong correction word");

   // The scaled humidity and temperature stay inside their physical ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.humidity_centi <= 14'd10000)
                        && (rsp_if.temperature_centi >= -15'sd4500)
                        && (rsp_if.temperature_centi <= 15'sd13000)))
      else $error("scaled value out of range");

   // A CRC error clears every value field; this check leaves the temperature out.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status == STATUS_CRC_ERROR))
         |-> ((rsp_if.co2_ppm == '0) && (rsp_if.recal_correction == '0)
              && (rsp_if.humidity_centi == '0) && !rsp_if.data_avail))
      else $error("CRC error result carries data");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the gas sensor response decoder: directed and random response frames.
module testbench;
   import gsrd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The fourth frame kind has no name in the package. The decoder treats it as a
   // one-word frame whose values are all zero.
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // The run is stopped here whatever happens. This is many times the slowest correct run,
   // which is about 600 requests, each with the longest sender gap and receiver stall.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_BYTES = 500;
   localparam int TAIL_CYCLES  = 20;

   // One decoded reading, as it appears on the response channel.
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [WORD_W-1:0]        co2;
      logic signed [TEMP_W-1:0] temp;
      logic [HUMID_W-1:0]       humid;
      logic                     ready;
      logic [WORD_W-1:0]        correction;
   } reading_type;

   // Follows the frame parser from each accepted request, holds the readings still to
   // come, and compares each response with the oldest of them.
   class reading_scoreboard;
      logic [KIND_W-1:0] kind;
      logic [3:0]        position;
      logic [7:0]        msb;
      logic [7:0]        lsb;
      logic [WORD_W-1:0] words [MAX_WORDS];
      bit                crc_bad;
      reading_type       awaited_readings [$];
      int                mismatches;
      int                readings_checked;
      int                crc_errors;
      int                recal_failures;
      int                meas_frames;
      int                status_frames;
      int                ignored_bytes;

      function new();
         kind = KIND_MEAS;
         position = '0;
         msb = '0;
         lsb = '0;
         foreach (words[i]) words[i] = '0;
         crc_bad = 1'b0;
      endfunction

      // CRC-8 over the two bytes of a word, one bit at a time, most significant first.
      function logic [7:0] word_crc(logic [WORD_W-1:0] w);
         logic [7:0] crc;
         logic       feedback;
         crc = CRC_INIT;
         for (int i = WORD_W - 1; i >= 0; i--) begin
            feedback = crc[7] ^ w[i];
            crc = {crc[6:0], 1'b0};
            if (feedback) crc = crc ^ CRC_POLY;
         end
         return crc;
      endfunction

      function logic [WORD_W-1:0] stored_word(int unsigned i);
         return (i < MAX_WORDS) ? words[i] : '0;
      endfunction

      // Turns the completed frame into the reading that the decoder should give.
      function reading_type decode_frame();
         reading_type r;
         logic [31:0] t;
         logic [31:0] h;
         r = '0;
         if (crc_bad) begin
            r.status = STATUS_CRC_ERROR;
            crc_errors++;
            return r;
         end
         r.status = STATUS_OK;
         case (kind)
            KIND_MEAS: begin
               t = (32'd17500 * {16'd0, stored_word(1)} + 32'd32767) / 32'd65535;
               h = (32'd10000 * {16'd0, stored_word(2)} + 32'd32767) / 32'd65535;
               r.co2   = stored_word(0);
               r.temp  = TEMP_W'(t - 32'd4500);
               r.humid = HUMID_W'(h);
               meas_frames++;
            end
            KIND_STATUS: begin
               r.ready = |(stored_word(0) & READY_MASK);
               status_frames++;
            end
            KIND_RECAL: begin
               r.correction = stored_word(0);
               if (stored_word(0) == RECAL_FAIL_WORD) begin
                  r.status = STATUS_RECAL_FAIL;
                  recal_failures++;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      // Notes one accepted request; returns 0 when the byte fell after the end of a frame.
      function bit take_byte(logic [7:0] data, logic first, logic [KIND_W-1:0] func);
         int unsigned n_words;
         int unsigned total;
         int unsigned pos;
         if (first) begin
            kind = func;
            position = '0;
            crc_bad = 1'b0;
         end
         n_words = (kind == KIND_MEAS) ? FRAME_WORDS_MAX : 1;
         total = 3 * n_words;
         pos = position;
         if (pos >= total) begin
            ignored_bytes++;
            return 1'b0;
         end
         case (pos % 3)
            0: msb = data;
            1: lsb = data;
            default: begin
               if (word_crc({msb, lsb}) != data) crc_bad = 1'b1;
               if (pos / 3 < MAX_WORDS) words[pos / 3] = {msb, lsb};
            end
         endcase
         position = 4'(pos + 1);
         if (pos + 1 == total) awaited_readings.push_back(decode_frame());
         return 1'b1;
      endfunction

      function string show(reading_type r);
         return $sformatf("status %0d co2 %0d temp %0d humid %0d ready %0b correction 0x%h",
                          r.status, r.co2, $signed(r.temp), r.humid, r.ready, r.correction);
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         bit          bad;
         if (awaited_readings.size() == 0) begin
            if (mismatches < 10) $display("%0t: response with none awaited: %s", $realtime,
                                          show(got));
            mismatches++;
            return;
         end
         want = awaited_readings.pop_front();
         readings_checked++;
         bad = (got.status !== want.status) || (got.co2 !== want.co2) ||
               (got.temp !== want.temp) || (got.humid !== want.humid) ||
               (got.ready !== want.ready) || (got.correction !== want.correction);
         if (bad) begin
            if (mismatches < 10) begin
               $display("%0t: reading mismatch, expected %s", $realtime, show(want));
               $display("%0t:                   actual   %s", $realtime, show(got));
            end
            mismatches++;
         end
      endfunction

      function int pending();
         return awaited_readings.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   counted_bytes;
   bit   tx_burst;
   bit   rx_burst;
   int   rx_stall_left;
   int   rx_phase_left;

   reading_scoreboard sb;

   gsrd_req_if req_bus ();
   gsrd_rsp_if rsp_bus ();

   gas_sensor_response_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Guard against a hung handshake: the run is ended as a failure past the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d readings awaited", cycle_count,
                  sb.pending());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Mostly no gap, sometimes a few cycles, now and then a long one. In a burst stretch
   // there is no gap at all.
   function automatic int gap_length(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Response side: every accepted response is checked at the edge, and ready is then
   // driven for the next cycle. Stalls come in random lengths, with stretches without any.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_reading('{status: rsp_bus.status, co2: rsp_bus.co2_ppm,
                               temp: rsp_bus.temperature_centi,
                               humid: rsp_bus.humidity_centi, ready: rsp_bus.data_avail,
                               correction: rsp_bus.recal_correction});
         end
         if (rx_phase_left == 0) begin
            rx_burst = ($urandom_range(0, 3) == 0);
            rx_phase_left = $urandom_range(50, 300);
         end else begin
            rx_phase_left--;
         end
         if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rx_stall_left = gap_length(rx_burst);
         end
      end
   end

   // Offers one request and waits until it is taken. Valid is left high, so a following
   // request can go out in the next cycle without a gap.
   task automatic send_byte(logic [7:0] data, logic first, logic [KIND_W-1:0] func);
      req_bus.rx_byte <= data;
      req_bus.first   <= first;
      req_bus.func    <= func;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      if (sb.take_byte(data, first, func)) counted_bytes++;
   endtask

   // Lowers valid for a gap. A zero gap leaves valid alone, so that it is never lowered and
   // raised again within one time step.
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds requests back until every awaited reading has come out.
   task automatic drain_readings();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // One word as its MSB, LSB and CRC triple; a spoilt CRC is flipped in some bits.
   task automatic send_word(logic [WORD_W-1:0] w, logic first, logic [KIND_W-1:0] func,
                            bit spoil);
      logic [7:0] crc;
      crc = sb.word_crc(w);
      if (spoil) crc = crc ^ 8'h5A;
      send_byte(w[15:8], first, func);
      send_byte(w[7:0], 1'b0, 2'($urandom));
      send_byte(crc, 1'b0, 2'($urandom));
   endtask

   // Word values lean towards the edges: zero, all ones, status words with and without
   // the low ready bits, and plain random words.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return RECAL_FAIL_WORD;
         2: return WORD_W'($urandom_range(1, 16'h07FF));
         3: return {5'($urandom), 11'd0};
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // A whole frame with random content, optionally with one bad CRC and optionally cut short
   // after a given number of bytes. Gaps fall between every pair of requests.
   task automatic send_frame(logic [KIND_W-1:0] kind, bit spoil, int cut);
      logic [7:0]        frame_bytes [$];
      logic [WORD_W-1:0] w;
      logic [7:0]        crc;
      int                n_words;
      int                bad_word;
      int                len;
      n_words = (kind == KIND_MEAS) ? FRAME_WORDS_MAX : 1;
      bad_word = spoil ? $urandom_range(0, n_words - 1) : -1;
      for (int i = 0; i < n_words; i++) begin
         w = pick_word();
         crc = sb.word_crc(w);
         if (i == bad_word) crc = crc ^ 8'($urandom_range(1, 255));
         frame_bytes.push_back(w[15:8]);
         frame_bytes.push_back(w[7:0]);
         frame_bytes.push_back(crc);
      end
      len = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int i = 0; i < len; i++) begin
         send_byte(frame_bytes[i], i == 0, (i == 0) ? kind : 2'($urandom));
         idle_sender(gap_length(tx_burst));
      end
   endtask

   initial begin
      logic [KIND_W-1:0] kind;
      bit                drained_mid;
      int                r;

      // Every input is known from time zero, while reset is held.
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      req_bus.first = 1'b0;
      req_bus.func = '0;
      rsp_bus.ready = 1'b0;
      cycle_count = 0;
      counted_bytes = 0;
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      rx_stall_left = 0;
      rx_phase_left = 0;
      drained_mid = 1'b0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Straight after reset no byte has been marked first, so the parser
      // must take an unmarked measurement frame; the unused func bits are set high here.
      // Its words give the largest CO2 value, the lowest temperature and full humidity.
      send_word(RECAL_FAIL_WORD, 1'b0, KIND_SPARE, 1'b0);
      send_word(16'h0000, 1'b0, KIND_SPARE, 1'b0);
      send_word(RECAL_FAIL_WORD, 1'b0, KIND_SPARE, 1'b0);
      // A status word whose low eleven bits are clear reports not ready.
      send_word(16'hF800, 1'b1, KIND_STATUS, 1'b0);
      // The all-ones correction word reports a failed recalibration.
      send_word(RECAL_FAIL_WORD, 1'b1, KIND_RECAL, 1'b0);
      // The spare frame kind with a bad CRC gives a CRC error reading.
      send_word(16'h1234, 1'b1, KIND_SPARE, 1'b1);
      // Bytes after a completed frame are dropped without a reading.
      send_byte(8'h00, 1'b0, KIND_MEAS);
      send_byte(8'hFF, 1'b0, KIND_SPARE);
      // A status word with only the lowest bit set reports ready.
      send_word(16'h0001, 1'b1, KIND_STATUS, 1'b0);
      drain_readings();

      // Random part: mostly whole frames, some cut short by a new first byte, some lone
      // bytes with random marking, and now and then trailing bytes after a frame.
      while (counted_bytes < TARGET_BYTES) begin
         if (!drained_mid && counted_bytes >= TARGET_BYTES / 2) begin
            drain_readings();
            drained_mid = 1'b1;
         end
         tx_burst = ($urandom_range(0, 9) == 0);
         kind = ($urandom_range(0, 99) < 8) ? KIND_SPARE : 2'($urandom_range(0, 2));
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_frame(kind, $urandom_range(0, 9) == 0, 0);
            if ($urandom_range(0, 99) < 15) begin
               repeat ($urandom_range(1, 3)) begin
                  send_byte(8'($urandom), 1'b0, 2'($urandom));
                  idle_sender(gap_length(tx_burst));
               end
            end
         end else if (r < 88) begin
            send_frame(kind, $urandom_range(0, 9) == 0, $urandom_range(1, 8));
         end else begin
            send_byte(8'($urandom), $urandom_range(0, 3) == 0, 2'($urandom));
            idle_sender(gap_length(tx_burst));
         end
      end

      // Let every awaited reading arrive, then allow a few more cycles for anything stray.
      drain_readings();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d decoded bytes and %0d dropped ones; %0d readings checked",
               counted_bytes, sb.ignored_bytes, sb.readings_checked);
      $display("readings: %0d measurement, %0d status, %0d crc errors, %0d recal failures",
               sb.meas_frames, sb.status_frames, sb.crc_errors, sb.recal_failures);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatching responses", sb.mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
